@@ hdl/cfte_pkg.sv @@
package cfte_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FD_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BASE = 1'd1;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FD_OFF    = 3'd1;
    localparam logic [2:0] ST_CLASSIC   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_NONCANON  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX = 3'd6;

    typedef struct packed {
        logic        cmd;
        logic [28:0] frame_id;
        logic        extended;
        logic        fd_request;
        logic [7:0]  byte_len;
        logic        fifo_full;
        logic [4:0]  put_index;
        logic [31:0] payload_word;
    } in_t;

    typedef struct packed {
        logic [31:0] element_word;
        logic [11:0] word_addr;
        logic [2:0]  status;
        logic [7:0]  request_mask;
        logic        last;
    } out_t;

    typedef enum logic [1:0] {
        OP_ERR  = 2'd0,
        OP_HDR  = 2'd1,
        OP_DATA = 2'd2
    } op_kind_t;

    // One queued operation. For a header, word is T0 and mask/last belong to T1.
    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] word;
        logic [11:0] addr;
        logic [3:0]  dlc;
        logic        fd;
        logic [2:0]  status;
        logic [7:0]  mask;
        logic        last;
    } op_t;

endpackage

@@ hdl/can_fd_tx_element_formatter.sv @@
// An item is classified by the front, queued, then loaded into the output register.
// Each payload or error item gives one result per cycle while m_ready holds; a start
// gives two results (T0 then T1) through the single output register in the back end.
// Reset: synchronous, active low on aresetn; clears config, frame state, the
// operation queue and the output valid. No clearing pass is needed.
module can_fd_tx_element_formatter #(
    parameter int RX_ENTRIES  = 8,
    parameter int TX_ENTRIES  = 8,
    parameter int ENTRY_WORDS = 18
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // item input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cfte_pkg::in_t                   s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output cfte_pkg::out_t                  m_data,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfte_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic          q_full;
    logic          q_push;
    cfte_pkg::op_t q_push_op;
    logic          q_pop;
    logic          q_head_valid;
    cfte_pkg::op_t q_head_op;

    // Accept whenever the queue has a free slot; the front classifies in the
    // same cycle and pushes one operation (ignored payloads push nothing).
    assign s_ready   = !q_full;
    // Configuration is always taken; the user writes it only while idle (unchecked).
    assign cfg_ready = 1'b1;

    cfte_front #(
        .RX_ENTRIES  (RX_ENTRIES),
        .TX_ENTRIES  (TX_ENTRIES),
        .ENTRY_WORDS (ENTRY_WORDS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_valid && s_ready),
        .in_data   (s_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (q_push),
        .push_op   (q_push_op)
    );

    // Two-slot queue decouples classification from word emission.
    cfte_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_push_op),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    // Back end expands headers into T0/T1 and holds results in the output register.
    cfte_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_op    (q_head_op),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ hdl/cfte_front.sv @@
module cfte_front #(
    parameter int RX_ENTRIES  = 8,
    parameter int TX_ENTRIES  = 8,
    parameter int ENTRY_WORDS = 18
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_accept,
    input  cfte_pkg::in_t                      in_data,
    input  logic                               cfg_write,
    input  logic [cfte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfte_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               push,
    output cfte_pkg::op_t                      push_op
);

    localparam logic [11:0] RX_SPAN = 12'(RX_ENTRIES * ENTRY_WORDS);
    localparam logic [11:0] EW      = 12'(ENTRY_WORDS);
    localparam logic [5:0]  TX_LIM  = 6'(TX_ENTRIES);

    logic        fd_enabled_reg;
    logic [11:0] slice_base_reg;

    logic        active_reg, active_next;
    logic [6:0]  rem_reg, rem_next;
    logic [11:0] addr_reg, addr_next;
    logic [2:0]  idx_reg, idx_next;

    logic [2:0]  status;
    logic [11:0] base;
    logic [3:0]  dlc;
    logic [31:0] t0;
    logic [31:0] data_word;
    logic [31:0] byte_keep;

    function automatic logic [3:0] dlc_of(input logic [7:0] len);
        logic [3:0] d;
        if (len <= 8'd8)       d = len[3:0];
        else if (len <= 8'd12) d = 4'd9;
        else if (len <= 8'd16) d = 4'd10;
        else if (len <= 8'd20) d = 4'd11;
        else if (len <= 8'd24) d = 4'd12;
        else if (len <= 8'd32) d = 4'd13;
        else if (len <= 8'd48) d = 4'd14;
        else                   d = 4'd15;
        return d;
    endfunction

    function automatic logic fd_len_ok(input logic [7:0] len);
        logic ok;
        case (len) inside
            8'd12, 8'd16, 8'd20, 8'd24, 8'd32, 8'd48, 8'd64: ok = 1'b1;
            default: ok = (len <= 8'd8);
        endcase
        return ok;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_enabled_reg <= 1'b0;
            slice_base_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                cfte_pkg::CFG_FD_ENABLED: fd_enabled_reg <= cfg_data[0];
                cfte_pkg::CFG_SLICE_BASE: slice_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (in_data.fd_request && !fd_enabled_reg)               status = cfte_pkg::ST_FD_OFF;
        else if (!in_data.fd_request && in_data.byte_len > 8'd8) status = cfte_pkg::ST_CLASSIC;
        else if (in_data.byte_len > 8'd64)                       status = cfte_pkg::ST_TOO_LONG;
        else if (!fd_len_ok(in_data.byte_len))                   status = cfte_pkg::ST_NONCANON;
        else if (in_data.fifo_full)                              status = cfte_pkg::ST_FULL;
        else if ({1'b0, in_data.put_index} >= TX_LIM)            status = cfte_pkg::ST_BAD_INDEX;
        else                                                     status = cfte_pkg::ST_OK;
    end

    assign base = slice_base_reg + RX_SPAN + 12'(in_data.put_index) * EW;
    assign dlc  = in_data.fd_request ? dlc_of(in_data.byte_len) : in_data.byte_len[3:0];
    assign t0   = in_data.extended ? {3'b010, in_data.frame_id}
                                   : {3'b000, in_data.frame_id[10:0], 18'b0};

    // Keep only the bytes still inside the frame on the closing word.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            byte_keep[8*b +: 8] = (rem_reg >= 7'd4 || 7'(b) < rem_reg) ? 8'hFF : 8'h00;
        end
    end
    assign data_word = in_data.payload_word & byte_keep;

    always_comb begin
        active_next = active_reg;
        rem_next    = rem_reg;
        addr_next   = addr_reg;
        idx_next    = idx_reg;
        push        = 1'b0;
        push_op     = '0;
        push_op.kind = cfte_pkg::OP_ERR;
        if (in_accept) begin
            if (in_data.cmd == cfte_pkg::CMD_START) begin
                push        = 1'b1;
                active_next = 1'b0;
                rem_next    = '0;
                if (status != cfte_pkg::ST_OK) begin
                    push_op.kind   = cfte_pkg::OP_ERR;
                    push_op.status = status;
                    push_op.last   = 1'b1;
                end else begin
                    idx_next       = in_data.put_index[2:0];
                    push_op.kind   = cfte_pkg::OP_HDR;
                    push_op.word   = t0;
                    push_op.addr   = base;
                    push_op.dlc    = dlc;
                    push_op.fd     = in_data.fd_request;
                    push_op.status = cfte_pkg::ST_OK;
                    if (in_data.byte_len == 8'd0) begin
                        push_op.mask = 8'(1) << in_data.put_index[2:0];
                        push_op.last = 1'b1;
                    end else begin
                        active_next = 1'b1;
                        rem_next    = in_data.byte_len[6:0];
                        addr_next   = base + 12'd2;
                    end
                end
            end else if (active_reg) begin
                push           = 1'b1;
                push_op.kind   = cfte_pkg::OP_DATA;
                push_op.word   = data_word;
                push_op.addr   = addr_reg;
                push_op.status = cfte_pkg::ST_OK;
                addr_next      = addr_reg + 12'd1;
                rem_next       = (rem_reg >= 7'd4) ? rem_reg - 7'd4 : 7'd0;
                if (rem_next == 7'd0) begin
                    active_next  = 1'b0;
                    push_op.mask = 8'(1) << idx_reg;
                    push_op.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            rem_reg    <= '0;
            addr_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            active_reg <= active_next;
            rem_reg    <= rem_next;
            addr_reg   <= addr_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

@@ hdl/cfte_queue.sv @@
module cfte_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cfte_pkg::op_t push_op,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output cfte_pkg::op_t head_op
);

    cfte_pkg::op_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ hdl/cfte_back.sv @@
module cfte_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  cfte_pkg::op_t  head_op,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output cfte_pkg::out_t m_data
);

    typedef enum logic [1:0] {
        BEAT_T0 = 2'b01,
        BEAT_T1 = 2'b10
    } beat_t;

    beat_t          beat_reg, beat_next;
    logic           m_valid_reg, m_valid_next;
    cfte_pkg::out_t m_data_reg, m_data_next;
    logic           load;

    assign load = !m_valid_reg || m_ready;

    always_comb begin
        beat_next    = beat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pop          = 1'b0;
        if (load) begin
            m_valid_next = head_valid;
            if (head_valid) begin
                m_data_next.status = head_op.status;
                unique case (head_op.kind)
                    cfte_pkg::OP_HDR: begin
                        unique case (beat_reg)
                            BEAT_T0: begin
                                m_data_next.element_word = head_op.word;
                                m_data_next.word_addr    = head_op.addr;
                                m_data_next.request_mask = '0;
                                m_data_next.last         = 1'b0;
                                beat_next                = BEAT_T1;
                            end
                            BEAT_T1: begin
                                m_data_next.element_word = {10'b0, head_op.fd, head_op.fd,
                                                            head_op.dlc, 16'b0};
                                m_data_next.word_addr    = head_op.addr + 12'd1;
                                m_data_next.request_mask = head_op.mask;
                                m_data_next.last         = head_op.last;
                                beat_next                = BEAT_T0;
                                pop                      = 1'b1;
                            end
                            default: beat_next = BEAT_T0;
                        endcase
                    end
                    default: begin
                        m_data_next.element_word = head_op.word;
                        m_data_next.word_addr    = head_op.addr;
                        m_data_next.request_mask = head_op.mask;
                        m_data_next.last         = head_op.last;
                        pop                      = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg    <= BEAT_T0;
            m_valid_reg <= 1'b0;
        end else begin
            beat_reg    <= beat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/cfte_checker.sv @@
module cfte_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input cfte_pkg::out_t m_data
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Request mask only on a closing word.
    a_mask_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.request_mask != 8'd0) |-> m_data.last)
        else $error("request mask without last");

    a_mask_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_data.request_mask))
        else $error("request mask not one-hot");

    // An error result is a single empty closing transfer.
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != cfte_pkg::ST_OK) |->
            m_data.last && (m_data.request_mask == 8'd0) &&
            (m_data.element_word == 32'd0) && (m_data.word_addr == 12'd0))
        else $error("malformed error result");

endmodule

bind can_fd_tx_element_formatter cfte_checker u_cfte_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int RX_ENTRIES  = 8;
    localparam int TX_ENTRIES  = 8;
    localparam int ENTRY_WORDS = 18;
    localparam int MAX_GAP     = 12;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    cfte_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    cfte_pkg::out_t                  m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [cfte_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cfte_pkg::CFG_DATA_W-1:0] cfg_data;

    can_fd_tx_element_formatter #(
        .RX_ENTRIES  (RX_ENTRIES),
        .TX_ENTRIES  (TX_ENTRIES),
        .ENTRY_WORDS (ENTRY_WORDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock: low half, then high half.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: a private copy of the registers and the frame tracker.
    logic        fd_on;
    logic [11:0] slice_base_q;
    logic        frm_open;
    logic [6:0]  bytes_left;
    logic [11:0] wr_addr;
    logic [2:0]  entry_sel;

    // Element words still owed by the block, oldest first.
    cfte_pkg::out_t pending_words[$];

    // Shared knobs between the stimulus and the result side.
    logic no_gaps;       // both sides skip idling while set
    int   rx_hold_len;   // one-shot long stall request for the receiver

    int fail_count;
    int items_accepted;
    int words_checked;
    int frames_closed;
    int starts_rejected;
    int idle_drops;

    // ------------------------------------------------------------------
    // Predictor: work out the element words one accepted transfer causes.
    // ------------------------------------------------------------------
    task automatic format_element(input cfte_pkg::in_t it, output int n_out);
        cfte_pkg::out_t r;
        logic [2:0]     st;
        logic [11:0]    base;
        logic [3:0]     dlc;
        logic [31:0]    w;
        logic [7:0]     len;
        logic           canon;
        n_out = 0;
        len   = it.byte_len;
        if (it.cmd == cfte_pkg::CMD_PAYLOAD) begin
            // Drop payload that arrives with no frame open.
            if (!frm_open) begin
                idle_drops++;
                return;
            end
            w = it.payload_word;
            if (bytes_left >= 7'd4) begin
                bytes_left = bytes_left - 7'd4;
            end else begin
                // Zero the bytes past the frame length.
                w = w & ((32'h1 << (8 * bytes_left)) - 32'h1);
                bytes_left = 7'd0;
            end
            r.element_word = w;
            r.word_addr    = wr_addr;
            r.status       = cfte_pkg::ST_OK;
            wr_addr        = wr_addr + 12'd1;
            if (bytes_left == 7'd0) begin
                frm_open       = 1'b0;
                r.request_mask = 8'h1 << entry_sel;
                r.last         = 1'b1;
                frames_closed++;
            end else begin
                r.request_mask = 8'h0;
                r.last         = 1'b0;
            end
            pending_words.push_back(r);
            n_out = 1;
            return;
        end

        // A start always abandons whatever frame was open.
        frm_open   = 1'b0;
        bytes_left = 7'd0;
        canon = (len <= 8) || (len == 12) || (len == 16) || (len == 20) ||
                (len == 24) || (len == 32) || (len == 48) || (len == 64);
        st = cfte_pkg::ST_OK;
        if (it.fd_request && !fd_on)            st = cfte_pkg::ST_FD_OFF;
        else if (!it.fd_request && len > 8)     st = cfte_pkg::ST_CLASSIC;
        else if (len > 64)                      st = cfte_pkg::ST_TOO_LONG;
        else if (!canon)                        st = cfte_pkg::ST_NONCANON;
        else if (it.fifo_full)                  st = cfte_pkg::ST_FULL;
        else if (it.put_index >= TX_ENTRIES)    st = cfte_pkg::ST_BAD_INDEX;

        if (st != cfte_pkg::ST_OK) begin
            r = '0;
            r.status = st;
            r.last   = 1'b1;
            pending_words.push_back(r);
            starts_rejected++;
            n_out = 1;
            return;
        end

        entry_sel = it.put_index[2:0];
        base = 12'(slice_base_q + RX_ENTRIES * ENTRY_WORDS + it.put_index * ENTRY_WORDS);

        // T0: identifier and XTD.
        r = '0;
        if (it.extended) r.element_word = {3'b010, it.frame_id};
        else             r.element_word = {3'b000, it.frame_id[10:0], 18'h0};
        r.word_addr = base;
        r.status    = cfte_pkg::ST_OK;
        pending_words.push_back(r);

        // T1: DLC with FDF and BRS for FD frames.
        if (!it.fd_request)  dlc = len[3:0];
        else if (len <= 8)   dlc = len[3:0];
        else if (len <= 12)  dlc = 4'd9;
        else if (len <= 16)  dlc = 4'd10;
        else if (len <= 20)  dlc = 4'd11;
        else if (len <= 24)  dlc = 4'd12;
        else if (len <= 32)  dlc = 4'd13;
        else if (len <= 48)  dlc = 4'd14;
        else                 dlc = 4'd15;
        r.element_word = {10'h0, it.fd_request, it.fd_request, dlc, 16'h0};
        r.word_addr    = base + 12'd1;
        if (len == 8'd0) begin
            r.request_mask = 8'h1 << entry_sel;
            r.last         = 1'b1;
            frames_closed++;
        end else begin
            r.request_mask = 8'h0;
            r.last         = 1'b0;
            frm_open       = 1'b1;
            bytes_left     = len[6:0];
            wr_addr        = base + 12'd2;
        end
        pending_words.push_back(r);
        n_out = 2;
    endtask

    // ------------------------------------------------------------------
    // Item builders: unused fields carry random noise.
    // ------------------------------------------------------------------
    function automatic cfte_pkg::in_t noise_item();
        logic [95:0]   raw;
        cfte_pkg::in_t v;
        raw = {$urandom, $urandom, $urandom};
        v   = raw[$bits(cfte_pkg::in_t)-1:0];
        return v;
    endfunction

    function automatic cfte_pkg::in_t start_item(input logic [28:0] id, input logic ext,
                                                 input logic fd, input logic [7:0] len,
                                                 input logic full, input logic [4:0] pi);
        cfte_pkg::in_t v;
        v            = noise_item();
        v.cmd        = cfte_pkg::CMD_START;
        v.frame_id   = id;
        v.extended   = ext;
        v.fd_request = fd;
        v.byte_len   = len;
        v.fifo_full  = full;
        v.put_index  = pi;
        return v;
    endfunction

    function automatic cfte_pkg::in_t data_item(input logic [31:0] word);
        cfte_pkg::in_t v;
        v              = noise_item();
        v.cmd          = cfte_pkg::CMD_PAYLOAD;
        v.payload_word = word;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender: entered and left at a falling edge; valid stays up between
    // back-to-back transfers.
    // ------------------------------------------------------------------
    task automatic send_item(input cfte_pkg::in_t item);
        int gap;
        int n;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        format_element(item, n);
        if (n > 0) items_accepted++;
        @(negedge aclk);
    endtask

    // Drop valid, let every owed word come back, then wait out any ignored payload
    // transfer that may still be in flight.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [cfte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [11:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == cfte_pkg::CFG_FD_ENABLED) fd_on = val[0];
        else                                 slice_base_q = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_bus_mode(input logic fd, input logic [11:0] base);
        wait_idle();
        write_reg(cfte_pkg::CFG_FD_ENABLED, {11'h0, fd});
        write_reg(cfte_pkg::CFG_SLICE_BASE, base);
    endtask

    // Random well-formed start for the current bus mode.
    function automatic cfte_pkg::in_t good_start();
        logic [7:0] lens [16];
        logic       fd;
        logic [7:0] len;
        lens = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8,
                 8'd12, 8'd16, 8'd20, 8'd24, 8'd32, 8'd48, 8'd64};
        fd  = fd_on ? 1'($urandom) : 1'b0;
        len = fd ? lens[$urandom_range(0, 15)] : 8'($urandom_range(0, 8));
        return start_item(29'($urandom), 1'($urandom), fd, len, 1'b0,
                          5'($urandom_range(0, TX_ENTRIES - 1)));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_payload();
        // Payload with no frame open must vanish.
        send_item(data_item(32'hDEAD_BEEF));
    endtask

    task automatic test_classic_frames();
        // Classic bus after reset: standard id with high bits set, zero length.
        send_item(start_item(29'h1FFF_FFFF, 1'b0, 1'b0, 8'd0, 1'b0, 5'd0));
        // Extended id at its maximum, full classic frame in the last entry.
        send_item(start_item(29'h1FFF_FFFF, 1'b1, 1'b0, 8'd8, 1'b0, 5'd7));
        send_item(data_item(32'hFFFF_FFFF));
        send_item(data_item(32'h0000_0000));
        // FD asked for on a classic bus, with every later check but the classic one failing too.
        send_item(start_item(29'h0, 1'b0, 1'b1, 8'd255, 1'b1, 5'd31));
        // Classic frame longer than eight bytes.
        send_item(start_item(29'h123, 1'b0, 1'b0, 8'd9, 1'b0, 5'd1));
    endtask

    task automatic test_fd_frames();
        set_bus_mode(1'b1, 12'd2272);
        send_item(start_item(29'h1, 1'b1, 1'b1, 8'd65, 1'b0, 5'd0));
        send_item(start_item(29'h2, 1'b0, 1'b1, 8'd255, 1'b1, 5'd31));
        send_item(start_item(29'h3, 1'b0, 1'b1, 8'd13, 1'b0, 5'd2));
        send_item(start_item(29'h4, 1'b0, 1'b1, 8'd8, 1'b1, 5'd2));
        send_item(start_item(29'h5, 1'b0, 1'b1, 8'd8, 1'b0, 5'd8));
        send_item(start_item(29'h6, 1'b0, 1'b1, 8'd8, 1'b0, 5'd31));
        // Zero-length FD frame closes on T1.
        send_item(start_item(29'h7FF, 1'b0, 1'b1, 8'd0, 1'b0, 5'd5));
        // Short tails: mask off the unused bytes of the last word.
        send_item(start_item(29'h0, 1'b0, 1'b1, 8'd1, 1'b0, 5'd6));
        send_item(data_item(32'hFFFF_FFFF));
        send_item(start_item(29'h0, 1'b1, 1'b0, 8'd3, 1'b0, 5'd4));
        send_item(data_item(32'hFFFF_FFFF));
        // Start during a frame: abandon the open one.
        send_item(start_item(29'h555, 1'b0, 1'b1, 8'd12, 1'b0, 5'd3));
        send_item(data_item(32'hA5A5_A5A5));
        send_item(start_item(29'hAAA_AAAA, 1'b1, 1'b1, 8'd2, 1'b0, 5'd7));
        send_item(data_item(32'hFFFF_FFFF));
        // Closed frame: next payload is ignored.
        send_item(data_item(32'h1234_5678));
        // Classic frame on an FD bus.
        send_item(start_item(29'h7F0, 1'b0, 1'b0, 8'd7, 1'b0, 5'd0));
        send_item(data_item(32'hFFFF_FFFF));
        send_item(data_item(32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic(input logic fd, input logic [11:0] base,
                                       input int n_items);
        int            target;
        int            pick;
        int            nwords;
        int            flaw;
        cfte_pkg::in_t it;
        set_bus_mode(fd, base);
        target = items_accepted + n_items;
        while (items_accepted < target) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 80) begin
                // Well-formed frame; one in eight is cut short.
                it     = good_start();
                nwords = (it.byte_len + 3) / 4;
                if (pick >= 70 && nwords > 0) nwords = $urandom_range(0, nwords - 1);
                send_item(it);
                repeat (nwords) send_item(data_item($urandom));
            end else if (pick < 95) begin
                // Start with one or two flaws injected.
                it = good_start();
                repeat ($urandom_range(1, 2)) begin
                    flaw = $urandom_range(0, 5);
                    case (flaw)
                        0: it.fd_request = 1'b1;
                        1: begin
                            it.fd_request = 1'b0;
                            it.byte_len   = 8'($urandom_range(9, 255));
                        end
                        2: it.byte_len  = 8'($urandom_range(65, 255));
                        3: it.byte_len  = 8'($urandom_range(9, 63));
                        4: it.fifo_full = 1'b1;
                        default: it.put_index = 5'($urandom_range(TX_ENTRIES, 31));
                    endcase
                end
                send_item(it);
            end else begin
                // Stray payload.
                send_item(data_item($urandom));
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        set_bus_mode(1'b1, 12'd0);
        // Hold the result side for a long stretch while input keeps coming.
        rx_hold_len = 300;
        no_gaps     = 1'b1;
        repeat (3) begin
            send_item(start_item(29'($urandom), 1'b1, 1'b1, 8'd64, 1'b0,
                                 5'($urandom_range(0, TX_ENTRIES - 1))));
            repeat (16) send_item(data_item($urandom));
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: draw a stall per result, or honor a long hold request.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_len > 0) begin
                gap         = rx_hold_len;
                rx_hold_len = 0;
                m_ready     = 1'b0;
                repeat (gap) @(negedge aclk);
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    m_ready = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid && rx_hold_len == 0);
            @(negedge aclk);
        end
    end

    // Compare each result transfer against the oldest owed word.
    always @(posedge aclk) begin
        cfte_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result word=%h addr=%h status=%0d mask=%h last=%b",
                         $time, m_data.element_word, m_data.word_addr, m_data.status,
                         m_data.request_mask, m_data.last);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (m_data.element_word !== want.element_word) begin
                    $display("%0t: element_word expected %h actual %h",
                             $time, want.element_word, m_data.element_word);
                    fail_count++;
                end
                if (m_data.word_addr !== want.word_addr) begin
                    $display("%0t: word_addr expected %h actual %h",
                             $time, want.word_addr, m_data.word_addr);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.request_mask !== want.request_mask) begin
                    $display("%0t: request_mask expected %h actual %h",
                             $time, want.request_mask, m_data.request_mask);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop if the block hangs.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = cfte_pkg::CFG_FD_ENABLED;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        rx_hold_len  = 0;
        fd_on        = 1'b0;
        slice_base_q = 12'd0;
        frm_open     = 1'b0;
        bytes_left   = 7'd0;
        wr_addr      = 12'd0;
        entry_sel    = 3'd0;
        fail_count      = 0;
        items_accepted  = 0;
        words_checked   = 0;
        frames_closed   = 0;
        starts_rejected = 0;
        idle_drops      = 0;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_idle_payload();
        test_classic_frames();
        test_fd_frames();
        test_random_traffic(1'b1, 12'd0, 420);
        test_random_traffic(1'b0, 12'd2272, 320);
        test_random_traffic(1'b1, 12'($urandom_range(0, 2272)), 420);
        test_random_traffic(1'b1, 12'd2272, 390);
        test_backpressure();

        wait_idle();
        repeat (8) @(negedge aclk);

        $display("Covered %0d productive transfers, %0d result words checked.",
                 items_accepted, words_checked);
        $display("Frames closed: %0d, starts rejected: %0d, idle payload dropped: %0d.",
                 frames_closed, starts_rejected, idle_drops);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
